>>> rtl/pnco_pkg.sv
// Shared constants, types and the arctangent table of the PLL oscillator stage.
// No dependencies; every other rtl file but pnco_checker refers to it by scoped names.
`default_nettype none

package pnco_pkg;

    localparam int PHASE_BITS    = 32;
    localparam int SINE_BITS     = 16;
    localparam int CORDIC_STAGES = 20;
    localparam int ITER_W        = $clog2(CORDIC_STAGES);
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);

    localparam int NOM_W  = 28;
    localparam int STEP_W = 32;
    localparam int CFG_W  = 32;

    // register indexes on the configuration port
    localparam logic REG_NOMINAL_FREQ = 1'b0;
    localparam logic REG_TIME_STEP    = 1'b1;

    localparam logic [NOM_W-1:0]  NOMINAL_FREQ_RST = 28'd3276800;
    localparam logic [STEP_W-1:0] TIME_STEP_RST    = 32'd214748;

    // 1/(2*pi) in Q0.32
    localparam logic signed [30:0] INV_TWO_PI_Q32 = 31'sd683565276;
    // CORDIC start vector, gain-compensated, 2^30 scale
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

    localparam logic [31:0] SINE_KEEP = ~((32'd1 << (32 - SINE_BITS)) - 32'd1);

    typedef struct packed {
        logic [31:0]        phase;
        logic signed [31:0] freq;
    } phase_item_t;

    // arctan(2^-i) in turns, 2^32 per turn
    function automatic logic signed [31:0] atan_turns(input logic [ITER_W-1:0] i);
        logic signed [31:0] r;
        case (i)
            5'd0:    r = 32'sd536870912;
            5'd1:    r = 32'sd316933406;
            5'd2:    r = 32'sd167458907;
            5'd3:    r = 32'sd85004756;
            5'd4:    r = 32'sd42667331;
            5'd5:    r = 32'sd21354465;
            5'd6:    r = 32'sd10679838;
            5'd7:    r = 32'sd5340245;
            5'd8:    r = 32'sd2670163;
            5'd9:    r = 32'sd1335087;
            5'd10:   r = 32'sd667544;
            5'd11:   r = 32'sd333772;
            5'd12:   r = 32'sd166886;
            5'd13:   r = 32'sd83443;
            5'd14:   r = 32'sd41722;
            5'd15:   r = 32'sd20861;
            5'd16:   r = 32'sd10430;
            5'd17:   r = 32'sd5215;
            5'd18:   r = 32'sd2608;
            5'd19:   r = 32'sd1304;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/pnco_front.sv
// Front end: takes the loop correction, forms the output frequency and steps
// the phase accumulator; holds the configuration registers. Uses pnco_pkg.
`default_nettype none

module pnco_front (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [31:0]                s_tdata,    // [31:0] loop_correction
    input  wire logic                       cfg_we,
    input  wire logic                       cfg_addr,
    input  wire logic [pnco_pkg::CFG_W-1:0] cfg_wdata,
    output logic                            push,
    output pnco_pkg::phase_item_t           push_item,
    input  wire logic                       q_full
);

    localparam int PB      = pnco_pkg::PHASE_BITS;
    localparam int INC_LSB = 48 - PB;

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_MUL  = 5'b00010,
        F_FREQ = 5'b00100,
        F_INC  = 5'b01000,
        F_ADD  = 5'b10000
    } front_state_t;

    front_state_t state_reg, state_next;

    logic [pnco_pkg::NOM_W-1:0]  nominal_reg;
    logic [pnco_pkg::STEP_W-1:0] step_reg;
    logic signed [31:0]          corr_reg;
    logic signed [62:0]          prod_reg;
    logic signed [31:0]          freq_reg, freq_next;
    logic signed [65:0]          incprod_reg;
    logic [PB-1:0]               acc_reg, acc_next;

    logic signed [63:0]          biased;
    logic signed [31:0]          corr_hz;
    logic signed [33:0]          freq_wide;
    logic [PB+31:0]              acc_wide;

    assign s_tready = (state_reg == F_IDLE);

    always_comb begin
        // floor(prod / 2^32 + 1/2)
        biased    = {prod_reg[62], prod_reg} + 64'sd2147483648;
        corr_hz   = biased[63:32];
        freq_wide = $signed({6'b0, nominal_reg}) - {{2{corr_hz[31]}}, corr_hz};
        if (freq_wide > 34'sd2147483647) begin
            freq_next = 32'sh7FFF_FFFF;
        end else if (freq_wide < -34'sd2147483648) begin
            freq_next = 32'sh8000_0000;
        end else begin
            freq_next = freq_wide[31:0];
        end
        acc_next = acc_reg + incprod_reg[INC_LSB +: PB];
        acc_wide = {acc_next, 32'b0};
    end

    assign push            = (state_reg == F_ADD) && !q_full;
    assign push_item.phase = acc_wide[PB+31 -: 32];
    assign push_item.freq  = freq_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:  if (s_tvalid) state_next = F_MUL;
            F_MUL:   state_next = F_FREQ;
            F_FREQ:  state_next = F_INC;
            F_INC:   state_next = F_ADD;
            F_ADD:   if (!q_full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= F_IDLE;
            acc_reg     <= '0;
            nominal_reg <= pnco_pkg::NOMINAL_FREQ_RST;
            step_reg    <= pnco_pkg::TIME_STEP_RST;
        end else begin
            state_reg <= state_next;
            if (push) acc_reg <= acc_next;
            if (cfg_we) begin
                case (cfg_addr)
                    pnco_pkg::REG_NOMINAL_FREQ: nominal_reg <= cfg_wdata[pnco_pkg::NOM_W-1:0];
                    pnco_pkg::REG_TIME_STEP:    step_reg    <= cfg_wdata[pnco_pkg::STEP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) corr_reg <= s_tdata;
        if (state_reg == F_MUL)   prod_reg <= corr_reg * pnco_pkg::INV_TWO_PI_Q32;
        if (state_reg == F_FREQ)  freq_reg <= freq_next;
        // signed frequency times unsigned step; low bits match the modular product
        if (state_reg == F_INC)
            incprod_reg <= $signed({freq_reg[31], freq_reg}) * $signed({1'b0, step_reg});
    end

endmodule

`default_nettype wire

>>> rtl/pnco_fifo.sv
// Short queue of phase/frequency items between front end and CORDIC back end.
// Uses pnco_pkg for the item type and depth.
`default_nettype none

module pnco_fifo (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire pnco_pkg::phase_item_t push_item,
    output logic                       full,
    input  wire logic                  pop,
    output pnco_pkg::phase_item_t      pop_item,
    output logic                       empty
);

    localparam int PW = pnco_pkg::QUEUE_PTR_W;

    pnco_pkg::phase_item_t slot_reg [pnco_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   count_reg;

    assign full     = (count_reg == (PW+1)'(pnco_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push && !full)  wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (pop && !empty)  rd_ptr_reg <= rd_ptr_reg + PW'(1);
            if ((push && !full) && !(pop && !empty)) begin
                count_reg <= count_reg + (PW+1)'(1);
            end else if (!(push && !full) && (pop && !empty)) begin
                count_reg <= count_reg - (PW+1)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !full) slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

>>> rtl/pnco_cordic.sv
// Back end: iterative rotation CORDIC, one stage a cycle, quadrant fold,
// Q1.15 rounding and the registered result stage. Uses pnco_pkg.
`default_nettype none

module pnco_cordic (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  q_empty,
    output logic                       pop,
    input  wire pnco_pkg::phase_item_t pop_item,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [95:0]                m_tdata
);

    localparam int IW = pnco_pkg::ITER_W;

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_ROT  = 3'b010,
        B_OUT  = 3'b100
    } back_state_t;

    back_state_t state_reg, state_next;

    logic signed [33:0] x_reg, y_reg;
    logic signed [31:0] z_reg;
    logic [IW-1:0]      iter_reg;
    logic [1:0]         quad_reg;
    logic [31:0]        phase_reg;
    logic signed [31:0] freq_reg;
    logic               m_valid_reg;
    logic [95:0]        m_data_reg;

    logic signed [33:0] xs, ys, sv, cv;
    logic [31:0]        a;
    logic               load_out;

    function automatic logic [15:0] to_q15(input logic signed [33:0] v);
        logic signed [33:0] r;
        r = (v + 34'sd16384) >>> 15;
        if (r > 34'sd32767)       return 16'h7FFF;
        else if (r < -34'sd32768) return 16'h8000;
        else                      return r[15:0];
    endfunction

    assign a        = pop_item.phase & pnco_pkg::SINE_KEEP;
    assign pop      = (state_reg == B_IDLE) && !q_empty;
    assign load_out = (state_reg == B_OUT) && (!m_valid_reg || m_tready);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        xs = x_reg >>> iter_reg;
        ys = y_reg >>> iter_reg;
        case (quad_reg)
            2'd0:    begin sv = y_reg;  cv = x_reg;  end
            2'd1:    begin sv = x_reg;  cv = -y_reg; end
            2'd2:    begin sv = -y_reg; cv = -x_reg; end
            default: begin sv = -x_reg; cv = y_reg;  end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:  if (!q_empty) state_next = B_ROT;
            B_ROT:   if (iter_reg == IW'(pnco_pkg::CORDIC_STAGES - 1)) state_next = B_OUT;
            B_OUT:   if (load_out) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out)      m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            x_reg     <= pnco_pkg::CORDIC_X0;
            y_reg     <= '0;
            z_reg     <= $signed({2'b00, a[29:0]});
            iter_reg  <= '0;
            quad_reg  <= a[31:30];
            phase_reg <= pop_item.phase;
            freq_reg  <= pop_item.freq;
        end else if (state_reg == B_ROT) begin
            if (!z_reg[31]) begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - pnco_pkg::atan_turns(iter_reg);
            end else begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + pnco_pkg::atan_turns(iter_reg);
            end
            iter_reg <= iter_reg + IW'(1);
        end
        if (load_out) m_data_reg <= {freq_reg, to_q15(cv), to_q15(sv), phase_reg};
    end

endmodule

`default_nettype wire

>>> rtl/pll_nco_phase_sincos.sv
// Top level of the PLL oscillator stage: front end, item queue, CORDIC back end.
// Depends on pnco_pkg, pnco_front, pnco_fifo and pnco_cordic.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------------------
//  s_       | in        | s_tvalid/s_tready  | loop_correction
//  m_       | out       | m_tvalid/m_tready  | phase_turns, sine_out, cosine_out, freq
//  cfg_     | in        | cfg_we             | nominal_freq (0), time_step (1)
//
// Front end works on one item at a time (multiply, frequency, multiply, add).
// Sustained rate is set by the 20-stage iterative CORDIC, which takes one item at a time.
// An accepted item passes front end, queue, CORDIC rotation and result register in turn.
// Reset is synchronous, active low; it clears control state and the phase and loads the config defaults.
// A stalled output holds its register; the queue lets the front keep working until it is full.
`default_nettype none

module pll_nco_phase_sincos (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [31:0]                s_tdata,  // [31:0] loop_correction
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // [31:0] phase_turns, [47:32] sine_out, [63:48] cosine_out, [95:64] output_freq
    output logic [95:0]                     m_tdata,
    input  wire logic                       cfg_we,
    input  wire logic                       cfg_addr,
    input  wire logic [pnco_pkg::CFG_W-1:0] cfg_wdata
);

    logic                  push, full, pop, empty;
    pnco_pkg::phase_item_t push_item, pop_item;

    pnco_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .push_item (push_item),
        .q_full    (full)
    );

    pnco_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (empty)
    );

    pnco_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (empty),
        .pop       (pop),
        .pop_item  (pop_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

>>> rtl/pnco_checker.sv
// Port-level checks for the PLL oscillator stage, bound to the top level.
// Depends on pll_nco_phase_sincos being elaborated.
`default_nettype none

module pnco_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [95:0] m_tdata
);

    // no result survives reset
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // front end is ready straight after reset
    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("s_tready low after reset");

    // one item at a time in the front end
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("s_tready held high after an accepted item");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind pll_nco_phase_sincos pnco_checker u_pnco_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
